[hw/rtl/pulse_baseline_and_shape_fractions_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the pulse shape RTL.
// ----------------------------------------------------------------------------
`ifndef PULSE_BASELINE_AND_SHAPE_FRACTIONS_TOP_MACROS_SVH
`define PULSE_BASELINE_AND_SHAPE_FRACTIONS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PBSF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define PBSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PBSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PBSF_ASSERT(lbl, clk, rstn, prop)
`define PBSF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PBSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/pbsf_pkg.sv]
// ----------------------------------------------------------------------------
// pbsf_pkg
// Widths, register indexes and shared types of the pulse shape block.
// ----------------------------------------------------------------------------
package pbsf_pkg;

    localparam int ETA_W      = 7;
    localparam int CHARGE_W   = 24;
    localparam int RAW_W      = 25;
    localparam int BASEACC_W  = 27;
    localparam int BASE_W     = 26;
    localparam int AMP_W      = 28;
    localparam int TOTAL_W    = 30;
    localparam int DIVIDEND_W = 27;
    localparam int DIVISOR_W  = 28;
    localparam int FRAC_W     = 17;
    localparam int STEP_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 248;

    localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK  = 3'd4;

    localparam logic [5:0]  ETA_LIMIT_RST = 6'd27;
    localparam logic [5:0]  GAP_LOW_RST   = 6'd14;
    localparam logic [5:0]  GAP_HIGH_RST  = 6'd19;
    localparam logic [15:0] MIN_SUM_RST   = 16'd80;
    localparam logic [15:0] MIN_PEAK_RST  = 16'd80;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[hw/rtl/pulse_baseline_and_shape_fractions_top.sv]
// ----------------------------------------------------------------------------
// pulse_baseline_and_shape_fractions_top
// Pulse baseline subtraction, quality cuts and window shape fractions.
// ----------------------------------------------------------------------------
// Samples of one pulse arrive on the s_ channel, one beat per cycle, s_tlast
// on the final sample. Samples 0..2 build the baseline, samples 3..6 the
// window; later samples are counted and dropped. Sample beats are taken back
// to back while the block collects.
// On the last beat the pulse is judged. A pulse that fails the count, eta,
// flat or baseline test gives no result and the next pulse can start in the
// next cycle; one that fails the amplitude or sum cuts holds s_tready low
// through the amplitude build-up and the cut check. A passing pulse holds
// s_tready low through amplitude build-up, the cut check, four divisions on
// the shared restoring divider and the load of the output register; the load
// waits while that register is still full, and m_tvalid goes high with it.
// One beat on m_ carries the amplitudes, sums and fractions. It sits in an
// output register until m_tready; the next pulse is collected meanwhile, and
// only its own result waits, with s_tready low, while the register is full.
// Registers are written on the cfg_ channel (cfg_ready is always high).
// aresetn clears the pulse state, the output valid and loads the register
// defaults.
// ----------------------------------------------------------------------------
module pulse_baseline_and_shape_fractions_top import pbsf_pkg::*; #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // eta[6:0], charge[30:7], pedestal[54:31]
    input  logic                  s_tlast,   // last_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // amp3, amp4, amp5, amp6, window_sum, baseline_sum, frac3, frac4, frac5, frac6
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_AMP,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t                      state_reg;
    logic [5:0]                  eta_limit_reg;
    logic [5:0]                  gap_low_reg;
    logic [5:0]                  gap_high_reg;
    logic [15:0]                 min_sum_reg;
    logic [15:0]                 min_peak_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [BASEACC_W-1:0] base_acc_reg;
    logic signed [RAW_W-1:0]     wraw_reg [4];
    logic signed [CHARGE_W-1:0]  first_q_reg;
    logic                        flat_reg;
    logic                        eta_ok_reg;
    logic [1:0]                  k_reg;
    logic [BASE_W-1:0]           base_reg;
    logic signed [AMP_W-1:0]     amp_reg [4];
    logic signed [TOTAL_W-1:0]   total_reg;
    logic [FRAC_W-1:0]           frac_reg [4];
    logic                        m_tvalid_reg;
    logic [M_TDATA_W-1:0]        m_tdata_reg;

    logic signed [ETA_W-1:0]     s_eta;
    logic signed [CHARGE_W-1:0]  s_charge;
    logic signed [CHARGE_W-1:0]  s_ped;
    logic signed [RAW_W-1:0]     s_raw;
    logic [ETA_W-1:0]            eta_abs;
    logic                        eta_ok_now;
    logic                        s_fire;
    logic [1:0]                  wr_idx;
    logic                        pulse_ok;
    logic signed [AMP_W-1:0]     wr_ext;
    logic signed [AMP_W-1:0]     amp_calc;
    logic [17:0]                 pk3;
    logic [17:0]                 sm3;
    logic                        cuts_fail;
    logic                        out_free;
    logic                        div_start;
    logic [FRAC_W-1:0]           div_quo;
    div_stat_t                   div_stat;

    assign s_eta    = s_tdata[6:0];
    assign s_charge = s_tdata[30:7];
    assign s_ped    = s_tdata[54:31];
    assign s_raw    = RAW_W'(s_charge) + RAW_W'(s_ped);
    assign eta_abs  = s_eta[ETA_W-1] ? (~s_tdata[6:0] + 7'd1) : s_tdata[6:0];
    assign eta_ok_now = !((eta_abs > {1'b0, eta_limit_reg}) ||
                          ((eta_abs > {1'b0, gap_low_reg}) &&
                           (eta_abs < {1'b0, gap_high_reg})));

    assign s_tready = (state_reg == ST_COLLECT);
    assign s_fire   = s_tvalid && s_tready;
    assign wr_idx   = 2'(cnt_reg - CNT_W'(3));
    assign pulse_ok = (cnt_reg >= CNT_W'(6)) && eta_ok_reg && !flat_reg &&
                      !base_acc_reg[BASEACC_W-1];

    assign wr_ext   = AMP_W'(wraw_reg[k_reg]);
    assign amp_calc = (wr_ext <<< 1) + wr_ext - $signed({2'b00, base_reg});

    assign pk3 = {1'b0, min_peak_reg, 1'b0} + {2'b00, min_peak_reg};
    assign sm3 = {1'b0, min_sum_reg, 1'b0} + {2'b00, min_sum_reg};
    assign cuts_fail = amp_reg[0][AMP_W-1] || amp_reg[1][AMP_W-1] ||
                       amp_reg[2][AMP_W-1] || amp_reg[3][AMP_W-1] ||
                       (amp_reg[1][AMP_W-2:0] < (AMP_W-1)'(pk3)) ||
                       total_reg[TOTAL_W-1] ||
                       (total_reg[TOTAL_W-2:0] < (TOTAL_W-1)'(sm3));

    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = (state_reg == ST_DIV_GO);
    assign cfg_ready = 1'b1;

    pbsf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (amp_reg[k_reg][DIVIDEND_W-1:0]),
        .divisor  (total_reg[DIVISOR_W-1:0]),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            eta_limit_reg <= ETA_LIMIT_RST;
            gap_low_reg   <= GAP_LOW_RST;
            gap_high_reg  <= GAP_HIGH_RST;
            min_sum_reg   <= MIN_SUM_RST;
            min_peak_reg  <= MIN_PEAK_RST;
            cnt_reg       <= '0;
            base_acc_reg  <= '0;
            flat_reg      <= 1'b1;
            eta_ok_reg    <= 1'b0;
            k_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ETA_LIMIT: eta_limit_reg <= cfg_data[5:0];
                    CFG_GAP_LOW:   gap_low_reg   <= cfg_data[5:0];
                    CFG_GAP_HIGH:  gap_high_reg  <= cfg_data[5:0];
                    CFG_MIN_SUM:   min_sum_reg   <= cfg_data;
                    CFG_MIN_PEAK:  min_peak_reg  <= cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_COLLECT: begin
                    if (s_fire) begin
                        if (cnt_reg == '0) begin
                            first_q_reg <= s_charge;
                            eta_ok_reg  <= eta_ok_now;
                        end
                        if (cnt_reg < CNT_W'(3)) begin
                            base_acc_reg <= base_acc_reg + BASEACC_W'(s_raw);
                        end else if (cnt_reg < CNT_W'(7)) begin
                            wraw_reg[wr_idx] <= s_raw;
                        end
                        if ((cnt_reg == CNT_W'(4)) || (cnt_reg == CNT_W'(5))) begin
                            flat_reg <= flat_reg && (s_charge == first_q_reg);
                        end
                        if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        if (s_tlast) begin
                            cnt_reg      <= '0;
                            base_acc_reg <= '0;
                            flat_reg     <= 1'b1;
                            eta_ok_reg   <= 1'b0;
                            base_reg     <= base_acc_reg[BASE_W-1:0];
                            total_reg    <= '0;
                            k_reg        <= '0;
                            if (pulse_ok) begin
                                state_reg <= ST_AMP;
                            end
                        end
                    end
                end
                ST_AMP: begin
                    amp_reg[k_reg] <= amp_calc;
                    total_reg      <= total_reg + TOTAL_W'(amp_calc);
                    k_reg          <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    state_reg <= cuts_fail ? ST_COLLECT : ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_stat.done) begin
                        frac_reg[k_reg] <= div_quo;
                        k_reg           <= k_reg + 2'd1;
                        state_reg       <= (k_reg == 2'd3) ? ST_OUT : ST_DIV_GO;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000,
                                         frac_reg[3], frac_reg[2],
                                         frac_reg[1], frac_reg[0],
                                         base_reg,
                                         3'b000, total_reg[DIVISOR_W-1:0],
                                         2'b00, amp_reg[3],
                                         2'b00, amp_reg[2],
                                         2'b00, amp_reg[1],
                                         2'b00, amp_reg[0]};
                        state_reg    <= ST_COLLECT;
                    end
                end
                default: begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "pulse_baseline_and_shape_fractions_top_macros.svh"

    `PBSF_ASSERT_IMPL(a_done_in_wait, aclk, aresetn, div_stat.done, state_reg == ST_DIV_WAIT)
    `PBSF_ASSERT_NEXT(a_short_reject, aclk, aresetn,
                      s_fire && s_tlast && (cnt_reg < CNT_W'(6)), state_reg == ST_COLLECT)
    `PBSF_ASSERT_NEXT(a_out_load, aclk, aresetn,
                      (state_reg == ST_OUT) && out_free, m_tvalid_reg)
    `PBSF_ASSERT(a_cnt_sat, aclk, aresetn, cnt_reg <= CNT_W'(MAX_SAMPLES))

endmodule

[hw/rtl/pbsf_div.sv]
// ----------------------------------------------------------------------------
// pbsf_div
// Restoring divider, one quotient bit per cycle: floor(dividend*2^16/divisor).
// ----------------------------------------------------------------------------
module pbsf_div import pbsf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [FRAC_W-1:0]     quotient,
    output div_stat_t             stat
);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DIVISOR_W:0]   rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [FRAC_W-1:0]    quo_reg;
    logic [DIVISOR_W+1:0] diff;
    logic                 ge;
    logic [DIVISOR_W-1:0] rem_sel;

    assign diff    = {1'b0, rem_reg} - {2'b00, dsr_reg};
    assign ge      = !diff[DIVISOR_W+1];
    assign rem_sel = ge ? diff[DIVISOR_W-1:0] : rem_reg[DIVISOR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(FRAC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {2'b00, dividend};
            dsr_reg  <= divisor;
            zero_reg <= (divisor == '0);
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {rem_sel, 1'b0};
            quo_reg  <= {quo_reg[FRAC_W-2:0], ge};
        end
    end

    assign quotient  = zero_reg ? '0 : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`include "pulse_baseline_and_shape_fractions_top_macros.svh"

    `PBSF_ASSERT_IMPL(a_start_idle, aclk, aresetn, start, !busy_reg)
    `PBSF_ASSERT_IMPL(a_step_range, aclk, aresetn, busy_reg, step_reg < STEP_W'(FRAC_W))
    `PBSF_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg && !busy_reg)

endmodule
